// ===== src/gcm_pkg.sv =====
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared types and constants of the gradient colour map: stop packing,
// register indexes, pipeline geometry and the segment record passed from
// the segment search to the channel interpolators.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int MAX_STOPS   = 7;
  localparam int STOP_IDX_W  = $clog2(MAX_STOPS);
  localparam int COUNT_W     = 3;
  localparam int POS_W       = 8;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHANS   = 4;
  localparam int COLOUR_W    = CHAN_W * NUM_CHANS;
  localparam int STOP_W      = POS_W + COLOUR_W;
  localparam int CFG_IDX_W   = 3;

  // Divider: one quotient bit per step, a few steps per register stage.
  localparam int NUM_W          = 2 * CHAN_W;
  localparam int QUO_W          = CHAN_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  // Segment register, product register, divider stages, output register.
  localparam int PIPE_DEPTH = 1 + 1 + DIV_STAGES + 1;

  localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_STOPS);

  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    colour_t          colour;
  } stop_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_COUNT = 3'd0,
    CFG_STOP_0     = 3'd1,
    CFG_STOP_1     = 3'd2,
    CFG_STOP_2     = 3'd3,
    CFG_STOP_3     = 3'd4,
    CFG_STOP_4     = 3'd5,
    CFG_STOP_5     = 3'd6,
    CFG_STOP_6     = 3'd7
  } cfg_idx_t;

  localparam stop_t STOP0_RESET = '{pos: 8'h00, colour: 32'hFF00_0000};
  localparam stop_t STOP1_RESET = '{pos: 8'hFF, colour: 32'hFFFF_FFFF};
  localparam stop_t STOPN_RESET = '{pos: 8'h00, colour: 32'h0000_0000};

  // Selected segment: offset into it, its width (never zero), end colours.
  typedef struct packed {
    logic [POS_W-1:0] d;
    logic [POS_W-1:0] w;
    colour_t          c1;
    colour_t          c2;
  } seg_t;

endpackage

// ===== src/gcm_level_if.sv =====
// ----------------------------------------------------------------------------
// gcm_level_if
// Input channel of the gradient colour map: one 8-bit level per beat.
// ----------------------------------------------------------------------------
interface gcm_level_if;
  import gcm_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

// ===== src/gcm_colour_if.sv =====
// ----------------------------------------------------------------------------
// gcm_colour_if
// Result channel of the gradient colour map: one RGBA colour per beat.
// ----------------------------------------------------------------------------
interface gcm_colour_if;
  import gcm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

// ===== src/gradient_colour_map.sv =====
// ----------------------------------------------------------------------------
// gradient_colour_map
// Maps an 8-bit level to an RGBA colour from a piecewise-linear gradient of
// up to seven configured stops.
// ----------------------------------------------------------------------------
// The block takes one level beat per clock unless a finished beat is held
// at the output, and returns one colour beat per level, in order, through
// one stage for the segment search, one for the product, four for the
// divider that produces two quotient bits each, and one output register;
// the fully pipelined divider keeps that rate. A stall on the result side
// holds the whole pipeline: in_if.ready follows out_if.ready whenever a
// result is waiting, and nothing is lost or repeated. The level picks the
// first segment whose two stop positions enclose it; a level outside every
// segment gets the colour of the last active stop, and a zero-width segment
// gives its first colour. Write the stop count and stops only while the
// block is idle; positions should ascend, but are used as written.
// ----------------------------------------------------------------------------
module gradient_colour_map
  import gcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  gcm_level_if.sink            in_if,
  gcm_colour_if.source         out_if,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STOP_W-1:0]    cfg_wdata
);

  logic [COUNT_W-1:0]     stop_count;
  stop_t [MAX_STOPS-1:0]  stops;
  seg_t                   seg;
  logic [CHAN_W-1:0]      chan [NUM_CHANS];
  logic                   advance;
  logic [PIPE_DEPTH-1:0]  vld_r;
  logic [PIPE_DEPTH-1:0]  vld_nxt;

  gcm_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .stop_count (stop_count),
    .stops      (stops)
  );

  // Advance every stage together unless a finished beat waits at the output.
  assign advance     = !vld_r[PIPE_DEPTH-1] || out_if.ready;
  assign in_if.ready = advance;

  // Valid bits ride alongside the data stages.
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_if.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= vld_nxt;
    end
  end

  gcm_seg_sel u_seg (
    .clk        (clk),
    .en         (advance),
    .level      (in_if.level),
    .stop_count (stop_count),
    .stops      (stops),
    .seg        (seg)
  );

  // One interpolator per channel, R in the low byte up to A in the high byte.
  for (genvar c = 0; c < NUM_CHANS; c++) begin : g_chan
    gcm_lerp_chan u_lerp (
      .clk  (clk),
      .en   (advance),
      .d    (seg.d),
      .w    (seg.w),
      .c1   (seg.c1[c*CHAN_W +: CHAN_W]),
      .c2   (seg.c2[c*CHAN_W +: CHAN_W]),
      .chan (chan[c])
    );
  end

  assign out_if.valid = vld_r[PIPE_DEPTH-1];
  assign out_if.red   = chan[0];
  assign out_if.green = chan[1];
  assign out_if.blue  = chan[2];
  assign out_if.alpha = chan[3];

endmodule

// ===== src/gcm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gcm_cfg_regs
// Stop count and stop registers, written through the plain write port.
// ----------------------------------------------------------------------------
module gcm_cfg_regs
  import gcm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STOP_W-1:0]          cfg_wdata,
  output logic [COUNT_W-1:0]         stop_count,
  output stop_t [MAX_STOPS-1:0]      stops
);

  logic [COUNT_W-1:0]    count_r;
  stop_t [MAX_STOPS-1:0] stops_r;
  logic [STOP_IDX_W-1:0] wr_slot;

  assign wr_slot = STOP_IDX_W'(cfg_index - CFG_STOP_0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= MIN_COUNT;
      for (int k = 0; k < MAX_STOPS; k++) begin
        stops_r[k] <= (k == 0) ? STOP0_RESET :
                      (k == 1) ? STOP1_RESET : STOPN_RESET;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_STOP_COUNT) begin
        count_r <= cfg_wdata[COUNT_W-1:0];
      end else begin
        stops_r[wr_slot] <= cfg_wdata;
      end
    end
  end

  assign stop_count = count_r;
  assign stops      = stops_r;

endmodule

// ===== src/gcm_seg_sel.sv =====
// ----------------------------------------------------------------------------
// gcm_seg_sel
// First pipeline stage: find the first enclosing segment for the level and
// register its offset, width and end colours.
// ----------------------------------------------------------------------------
module gcm_seg_sel
  import gcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [POS_W-1:0]      level,
  input  logic [COUNT_W-1:0]    stop_count,
  input  stop_t [MAX_STOPS-1:0] stops,
  output seg_t                  seg
);

  logic [COUNT_W-1:0]    n_eff;
  logic [STOP_IDX_W-1:0] last_idx;
  logic [STOP_IDX_W-1:0] hit_idx;
  logic [STOP_IDX_W-1:0] hit_nxt_idx;
  logic                  found;
  logic [POS_W-1:0]      w_raw;
  seg_t                  seg_nxt;
  seg_t                  seg_r;

  // Clamp the stop count into the legal range.
  always_comb begin
    priority if (stop_count < MIN_COUNT) begin
      n_eff = MIN_COUNT;
    end else if (stop_count > MAX_COUNT) begin
      n_eff = MAX_COUNT;
    end else begin
      n_eff = stop_count;
    end
  end

  assign last_idx = STOP_IDX_W'(n_eff - COUNT_W'(1));

  // First match wins.
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_STOPS - 1; i++) begin
      if (!found && (COUNT_W'(i + 1) < n_eff) &&
          (level >= stops[i].pos) && (level <= stops[i+1].pos)) begin
        found   = 1'b1;
        hit_idx = STOP_IDX_W'(i);
      end
    end
  end

  assign hit_nxt_idx = hit_idx + STOP_IDX_W'(1);
  assign w_raw       = stops[hit_nxt_idx].pos - stops[hit_idx].pos;

  // No match: hold the last stop's colour with a zero offset.
  // Zero-width segment: the offset is zero too, so any nonzero width will do.
  always_comb begin
    if (found) begin
      seg_nxt.d  = level - stops[hit_idx].pos;
      seg_nxt.w  = (w_raw == '0) ? POS_W'(1) : w_raw;
      seg_nxt.c1 = stops[hit_idx].colour;
      seg_nxt.c2 = stops[hit_nxt_idx].colour;
    end else begin
      seg_nxt.d  = '0;
      seg_nxt.w  = POS_W'(1);
      seg_nxt.c1 = stops[last_idx].colour;
      seg_nxt.c2 = stops[last_idx].colour;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r <= seg_nxt;
    end
  end

  assign seg = seg_r;

endmodule

// ===== src/gcm_lerp_chan.sv =====
// ----------------------------------------------------------------------------
// gcm_lerp_chan
// One colour channel: product stage, pipelined restoring divider and the
// floor correction, c1 + floor(d * (c2 - c1) / w).
// ----------------------------------------------------------------------------
module gcm_lerp_chan
  import gcm_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [POS_W-1:0]  d,
  input  logic [POS_W-1:0]  w,
  input  logic [CHAN_W-1:0] c1,
  input  logic [CHAN_W-1:0] c2,
  output logic [CHAN_W-1:0] chan
);

  // Index 0 is the product register, index k+1 follows divider stage k.
  logic [NUM_W-1:0]  rem_r [DIV_STAGES+1];
  logic [QUO_W-1:0]  quo_r [DIV_STAGES+1];
  logic [POS_W-1:0]  w_r   [DIV_STAGES+1];
  logic [CHAN_W-1:0] c1_r  [DIV_STAGES+1];
  logic              neg_r [DIV_STAGES+1];

  logic              neg;
  logic [CHAN_W-1:0] mag;
  logic [CHAN_W+1:0] sum;
  logic [CHAN_W-1:0] chan_r;

  // Product stage: magnitude of the colour step times the offset.
  assign neg = (c2 < c1);
  assign mag = neg ? (c1 - c2) : (c2 - c1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= NUM_W'(d) * NUM_W'(mag);
      quo_r[0] <= '0;
      w_r[0]   <= w;
      c1_r[0]  <= c1;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [NUM_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_nxt;

    always_comb begin
      logic [NUM_W-1:0] sub;
      rem_nxt = rem_r[k];
      quo_nxt = quo_r[k];
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        sub = NUM_W'(w_r[k]) << (QUO_W - 1 - k * BITS_PER_STAGE - j);
        if (rem_nxt >= sub) begin
          rem_nxt = rem_nxt - sub;
          quo_nxt[QUO_W - 1 - k * BITS_PER_STAGE - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        quo_r[k+1] <= quo_nxt;
        w_r[k+1]   <= w_r[k];
        c1_r[k+1]  <= c1_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // Floor toward minus infinity: a falling step with a remainder takes one more.
  always_comb begin
    if (neg_r[DIV_STAGES]) begin
      sum = (CHAN_W+2)'(c1_r[DIV_STAGES]) - (CHAN_W+2)'(quo_r[DIV_STAGES])
            - (CHAN_W+2)'(rem_r[DIV_STAGES] != '0);
    end else begin
      sum = (CHAN_W+2)'(c1_r[DIV_STAGES]) + (CHAN_W+2)'(quo_r[DIV_STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= sum[CHAN_W-1:0];
    end
  end

  assign chan = chan_r;

endmodule

// ===== verif/gcm_colour_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_colour_checker
// Watches the level and colour channels and the register port of the
// gradient colour map. Keeps its own copy of the stops, predicts the colour
// of every accepted level, and compares each colour beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module gcm_colour_checker
  import gcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 lvl_valid,
  input  logic                 lvl_ready,
  input  logic [POS_W-1:0]     lvl_level,
  input  logic                 col_valid,
  input  logic                 col_ready,
  input  logic [CHAN_W-1:0]    col_red,
  input  logic [CHAN_W-1:0]    col_green,
  input  logic [CHAN_W-1:0]    col_blue,
  input  logic [CHAN_W-1:0]    col_alpha,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [STOP_W-1:0]    cfg_wdata,
  output int unsigned          mismatches,
  output int unsigned          colours_due
);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  typedef struct {
    logic [POS_W-1:0] level;
    rgba_t            colour;
  } due_t;

  logic [COUNT_W-1:0] count_q;
  stop_t              stops_q [MAX_STOPS];
  due_t               colours_due_q [$];

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Pick the first enclosing segment and interpolate with floor division;
  // fall back to the last active stop when no segment encloses the level.
  function automatic rgba_t gradient_colour(input logic [POS_W-1:0] lvl);
    int                n, seg, ch, w, d, c1, c2, num, v;
    bit                found;
    logic [CHAN_W-1:0] chan [NUM_CHANS];
    n = int'(count_q);
    if (n < 2) n = 2;
    if (n > MAX_STOPS) n = MAX_STOPS;
    found = 1'b0;
    for (ch = 0; ch < NUM_CHANS; ch++) begin
      chan[ch] = stops_q[n-1].colour[CHAN_W*ch +: CHAN_W];
    end
    for (seg = 0; seg < n - 1 && !found; seg++) begin
      if (lvl >= stops_q[seg].pos && lvl <= stops_q[seg+1].pos) begin
        found = 1'b1;
        w = int'(stops_q[seg+1].pos) - int'(stops_q[seg].pos);
        d = int'(lvl) - int'(stops_q[seg].pos);
        for (ch = 0; ch < NUM_CHANS; ch++) begin
          c1 = int'(stops_q[seg].colour[CHAN_W*ch +: CHAN_W]);
          c2 = int'(stops_q[seg+1].colour[CHAN_W*ch +: CHAN_W]);
          v  = c1;
          if (w != 0) begin
            num = d * (c2 - c1);
            if (num >= 0) v = c1 + num / w;
            else          v = c1 - ((-num + w - 1) / w);
          end
          chan[ch] = v[CHAN_W-1:0];
        end
      end
    end
    return '{red: chan[0], green: chan[1], blue: chan[2], alpha: chan[3]};
  endfunction

  always @(posedge clk) begin
    due_t  head;
    due_t  fresh;
    rgba_t got;
    if (!rst_n) begin
      mismatches = 0;
      count_q    = MIN_COUNT;
      stops_q[0] = STOP0_RESET;
      stops_q[1] = STOP1_RESET;
      for (int k = 2; k < MAX_STOPS; k++) stops_q[k] = STOPN_RESET;
      colours_due_q.delete();
    end else begin
      if (col_valid && col_ready) begin
        got = '{red: col_red, green: col_green, blue: col_blue, alpha: col_alpha};
        if (colours_due_q.size() == 0) begin
          report_mismatch($sformatf("colour beat %08h with no level waiting", got));
        end else begin
          head = colours_due_q.pop_front();
          if (got.red !== head.colour.red)
            report_mismatch($sformatf("level %02h red got %02h want %02h",
                                      head.level, got.red, head.colour.red));
          if (got.green !== head.colour.green)
            report_mismatch($sformatf("level %02h green got %02h want %02h",
                                      head.level, got.green, head.colour.green));
          if (got.blue !== head.colour.blue)
            report_mismatch($sformatf("level %02h blue got %02h want %02h",
                                      head.level, got.blue, head.colour.blue));
          if (got.alpha !== head.colour.alpha)
            report_mismatch($sformatf("level %02h alpha got %02h want %02h",
                                      head.level, got.alpha, head.colour.alpha));
        end
      end
      if (lvl_valid && lvl_ready) begin
        fresh.level  = lvl_level;
        fresh.colour = gradient_colour(lvl_level);
        colours_due_q.insert(colours_due_q.size(), fresh);
      end
      if (cfg_wr_en) begin
        if (cfg_idx_t'(cfg_index) == CFG_STOP_COUNT) begin
          count_q = cfg_wdata[COUNT_W-1:0];
        end else begin
          stops_q[int'(cfg_index) - int'(CFG_STOP_0)] = stop_t'(cfg_wdata);
        end
      end
    end
    colours_due = colours_due_q.size();
  end

endmodule

// ===== verif/tb_gradient_colour_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_colour_map
// Drives levels into the gradient colour map under several stop settings,
// from the reset gradient through zero-width, non-ascending and
// out-of-range-count cases to random gradients, with bursty input and a
// stalling receiver. A separate checker predicts and compares every colour.
// ----------------------------------------------------------------------------
module tb_gradient_colour_map;
  import gcm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_LEVELS = 40;

  // Receiver stall patterns.
  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STOP_W-1:0]    cfg_wdata;
  int unsigned          mismatches;
  int unsigned          colours_due;
  int unsigned          cycle_count = 0;
  int                   burst_left;

  gcm_level_if  level_ch ();
  gcm_colour_if colour_ch ();

  gradient_colour_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (level_ch),
    .out_if    (colour_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gcm_colour_checker colour_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .lvl_valid   (level_ch.valid),
    .lvl_ready   (level_ch.ready),
    .lvl_level   (level_ch.level),
    .col_valid   (colour_ch.valid),
    .col_ready   (colour_ch.ready),
    .col_red     (colour_ch.red),
    .col_green   (colour_ch.green),
    .col_blue    (colour_ch.blue),
    .col_alpha   (colour_ch.alpha),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .colours_due (colours_due)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost colour ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: hold each stall pattern for a random stretch, then switch.
  // Stream mode gives long stretches with no back-pressure at all.
  initial begin
    rx_mode_t mode;
    int       left;
    colour_ch.ready = 1'b0;
    mode = RX_STREAM;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        RX_STREAM: colour_ch.ready <= 1'b1;
        RX_COIN:   colour_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: colour_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   colour_ch.ready <= ((left % 12) < 4);
      endcase
    end
  end

  // Send one level beat; called and returns at a falling edge. Open a new
  // burst after a random gap when the current one runs out, and keep valid
  // high across a burst.
  task automatic send_level(input logic [POS_W-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        level_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    level_ch.valid <= 1'b1;
    level_ch.level <= lvl;
    do @(posedge clk); while (!level_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted colour has come out, then let
  // the pipeline settle.
  task automatic wait_for_colours();
    level_ch.valid <= 1'b0;
    burst_left = 0;
    while (colours_due != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // Write the stop count and all seven stops on back-to-back cycles.
  task automatic load_gradient(input logic [COUNT_W-1:0] count,
                               input stop_t grad [MAX_STOPS]);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_STOP_COUNT;
    cfg_wdata <= STOP_W'(count);
    @(negedge clk);
    for (int k = 0; k < MAX_STOPS; k++) begin
      cfg_index <= CFG_IDX_W'(int'(CFG_STOP_0) + k);
      cfg_wdata <= grad[k];
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    stop_t             grad [MAX_STOPS];
    logic [POS_W-1:0]  ramp_probe [8];
    logic [POS_W-1:0]  corner_probe [9];
    logic [POS_W-1:0]  p;
    logic [COUNT_W-1:0] count;
    int                n, style, pick, stride;

    ramp_probe   = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    corner_probe = '{8'h00, 8'h20, 8'h21, 8'h50, 8'h80,
                     8'hA0, 8'hC0, 8'hE8, 8'hFF};
    rst_n          = 1'b0;
    level_ch.valid = 1'b0;
    level_ch.level = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    burst_left     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset gradient: black at 0 to white at 255, two stops.
    foreach (ramp_probe[i]) send_level(ramp_probe[i]);
    wait_for_colours();

    // Seven stops: a zero-width first segment, falling and rising channels,
    // a non-ascending pair that never matches, and the last stop below 255
    // so both ends fall outside every segment.
    grad[0] = '{pos: 8'h20, colour: 32'h1080_FF00};
    grad[1] = '{pos: 8'h20, colour: 32'hFF00_00FF};
    grad[2] = '{pos: 8'h80, colour: 32'h00FF_FF00};
    grad[3] = '{pos: 8'h60, colour: 32'h8040_2010};
    grad[4] = '{pos: 8'hC0, colour: 32'hFFFF_00FF};
    grad[5] = '{pos: 8'hE0, colour: 32'h0000_0000};
    grad[6] = '{pos: 8'hF0, colour: 32'h7F01_FE80};
    load_gradient(3'd7, grad);
    foreach (corner_probe[i]) send_level(corner_probe[i]);
    wait_for_colours();

    // Counts below two act as two: only the first two stops count, so a
    // level above the zero-width pair takes the second stop's colour.
    load_gradient(3'd0, grad);
    send_level(8'h40);
    send_level(8'hF5);
    wait_for_colours();
    load_gradient(3'd1, grad);
    send_level(8'h10);
    send_level(8'h20);
    wait_for_colours();

    // Random gradients: mostly ascending stops with random spacing (ties
    // included), sometimes scattered positions, with saturated colours now
    // and then. Levels cluster on the stops as well as spreading uniformly.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      count  = (phase == 0) ? 3'd7 : (phase == 1) ? 3'd2 : COUNT_W'($urandom_range(0, 7));
      n      = (int'(count) < 2) ? 2 : int'(count);
      style  = $urandom_range(0, 3);
      stride = 512 / n;
      p      = ($urandom_range(0, 1) == 0) ? 8'h00 : POS_W'($urandom_range(0, 40));
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (style == 0) begin
          grad[k].pos = POS_W'($urandom_range(0, 255));
        end else begin
          grad[k].pos = p;
          p = (int'(p) + $urandom_range(0, stride) > 255) ?
              8'hFF : POS_W'(int'(p) + $urandom_range(0, stride));
        end
        grad[k].colour = ($urandom_range(0, 3) == 0) ?
                         (($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF) :
                         32'($urandom());
      end
      if (style == 1) grad[n-1].pos = 8'hFF;
      load_gradient(count, grad);

      for (int j = 0; j < PHASE_LEVELS; j++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5)      p = POS_W'($urandom_range(0, 255));
        else if (pick <= 7) p = grad[$urandom_range(0, n - 1)].pos +
                                POS_W'($urandom_range(0, 2)) - 8'd1;
        else if (pick == 8) p = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        else                p = grad[$urandom_range(0, n - 1)].pos;
        send_level(p);
        // Pause mid-phase once until the pipeline has fully drained.
        if (phase == RAND_PHASES / 2 && j == PHASE_LEVELS / 2) wait_for_colours();
      end
      wait_for_colours();
    end

    repeat (2 * PIPE_DEPTH) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
